### sv/sha1s_pkg.sv
// ----------------------------------------------------------------------------
// sha1s_pkg
// Shared types and constants of the streaming SHA-1 hash block.
// ----------------------------------------------------------------------------
package sha1s_pkg;

  localparam int unsigned ROUND_W = 7;
  localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  // Byte slots within a 64-byte block
  localparam logic [5:0] SLOT_LAST    = 6'd63;
  localparam logic [5:0] SLOT_PRE_LEN = 6'd55;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } sha1s_in_t;

  typedef struct packed {
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
    logic [31:0] digest_word4;
  } sha1s_out_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha1s_work_t;

  typedef struct packed {
    logic       absorb;
    logic [7:0] data;
    logic       load;
    logic       step;
  } sha1s_ctl_t;

  typedef struct packed {
    logic last_round;
  } sha1s_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } sha1s_state_t;

  localparam sha1s_work_t CHAIN_INIT = '{a: H0, b: H1, c: H2, d: H3, e: H4};

endpackage

### sv/sha1s_round.sv
// ----------------------------------------------------------------------------
// sha1s_round
// One SHA-1 round: selects f and K by round number and rotates the working
// variables.
// ----------------------------------------------------------------------------
module sha1s_round import sha1s_pkg::*; (
  input  sha1s_work_t        work_in,
  input  logic [31:0]        w,
  input  logic [ROUND_W-1:0] round,
  output sha1s_work_t        work_out
);

  logic [31:0] f;
  logic [31:0] k;

  always_comb begin
    if (round inside {[7'd0:7'd19]}) begin
      f = (work_in.b & work_in.c) | (~work_in.b & work_in.d);
      k = K0;
    end else if (round inside {[7'd20:7'd39]}) begin
      f = work_in.b ^ work_in.c ^ work_in.d;
      k = K1;
    end else if (round inside {[7'd40:7'd59]}) begin
      f = (work_in.b & work_in.c) | (work_in.b & work_in.d) | (work_in.c & work_in.d);
      k = K2;
    end else begin
      f = work_in.b ^ work_in.c ^ work_in.d;
      k = K3;
    end
  end

  always_comb begin
    work_out.a = {work_in.a[26:0], work_in.a[31:27]} + f + work_in.e + k + w;
    work_out.b = work_in.a;
    work_out.c = {work_in.b[1:0], work_in.b[31:2]};
    work_out.d = work_in.c;
    work_out.e = work_in.d;
  end

endmodule

### sv/sha1s_core.sv
// ----------------------------------------------------------------------------
// sha1s_core
// Compression engine: a 512-bit shift line that first gathers message bytes
// and then serves as the rolling 16-word schedule, working registers and the
// round counter around one shared round unit.
// ----------------------------------------------------------------------------
module sha1s_core import sha1s_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  sha1s_ctl_t    ctl,
  input  sha1s_work_t   chain,
  output sha1s_work_t   work,
  output sha1s_status_t status
);

  logic [511:0]       sched;
  logic [ROUND_W-1:0] round;
  logic [31:0]        w_now;
  logic [31:0]        w_mix;
  logic [31:0]        w_new;
  sha1s_work_t        work_next;

  // Word j of the line sits at sched[511-32*j -: 32]
  assign w_now = sched[511:480];
  assign w_mix = sched[95:64] ^ sched[255:224] ^ sched[447:416] ^ w_now;
  assign w_new = {w_mix[30:0], w_mix[31]};

  sha1s_round u_round (
    .work_in  (work),
    .w        (w_now),
    .round    (round),
    .work_out (work_next)
  );

  always_ff @(posedge clk) begin
    if (ctl.absorb) begin
      sched <= {sched[503:0], ctl.data};
    end else if (ctl.step) begin
      sched <= {sched[479:0], w_new};
    end
    if (ctl.load) begin
      work <= chain;
    end else if (ctl.step) begin
      work <= work_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round <= '0;
    end else if (ctl.load) begin
      round <= '0;
    end else if (ctl.step) begin
      round <= round + 1'b1;
    end
  end

  assign status.last_round = (round == LAST_ROUND);

endmodule

### sv/sha1_stream_hash.sv
// ----------------------------------------------------------------------------
// sha1_stream_hash
// SHA-1 over a byte stream: one message byte per append word, a finish word
// pads the message, returns the 160-bit digest and restarts the hash.
// ----------------------------------------------------------------------------
//
//   channel | signals                    | word
//   --------+----------------------------+--------------------------------
//   in      | in_valid, in_ready, in_data | req_type, data_byte
//   out     | out_valid, out_ready, out_data | digest_word0 .. digest_word4
//
// The 64th byte of a block starts the compression: the shared round unit
// runs the 80 rounds, one round per cycle, then the result is added into
// the chain. A finish word feeds the padding and length bytes at one per
// cycle, pausing for a compression if the padding completes a block, with
// a final compression after the length bytes, then holds the digest until
// taken. in_ready is high only while idle. Reset loads the initial chain
// and zeros the bit count; the byte buffer needs no clearing since every
// slot is written before a compression reads it.
//
module sha1_stream_hash import sha1s_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  sha1s_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output sha1s_out_t out_data
);

  sha1s_state_t  state;
  sha1s_state_t  state_next;
  sha1s_state_t  resume;
  sha1s_work_t   chain;
  sha1s_work_t   work;
  sha1s_ctl_t    ctl;
  sha1s_status_t status;
  logic [63:0]   bit_count;
  logic [63:0]   length;
  logic          pad_first;
  logic [5:0]    slot;
  logic          in_fire;

  assign slot    = bit_count[8:3];
  assign in_fire = in_valid && in_ready;

  sha1s_core u_core (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .chain  (chain),
    .work   (work),
    .status (status)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.req_type == REQ_FINISH) begin
            state_next = ST_PAD;
          end else if (slot == SLOT_LAST) begin
            state_next = ST_ROUND;
          end
        end
      end
      ST_PAD: begin
        if (slot == SLOT_LAST) begin
          state_next = ST_ROUND;
        end else if (slot == SLOT_PRE_LEN) begin
          state_next = ST_LEN;
        end
      end
      ST_LEN: begin
        if (slot == SLOT_LAST) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (status.last_round) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        state_next = resume;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs and core controls
  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    ctl.absorb = 1'b0;
    ctl.data   = ZERO_BYTE;
    ctl.step   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        ctl.absorb = in_valid && (in_data.req_type == REQ_APPEND);
        ctl.data   = in_data.data_byte;
      end
      ST_PAD: begin
        ctl.absorb = 1'b1;
        ctl.data   = pad_first ? PAD_BYTE : ZERO_BYTE;
      end
      ST_LEN: begin
        ctl.absorb = 1'b1;
        ctl.data   = length[63:56];
      end
      ST_ROUND: begin
        ctl.step = 1'b1;
      end
      ST_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    // Load working registers from the chain on the byte that completes a block
    ctl.load = ctl.absorb && (slot == SLOT_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Remember where to go once the chain has been updated
  always_ff @(posedge clk) begin
    if (rst) begin
      resume <= ST_IDLE;
    end else if (ctl.load) begin
      case (state)
        ST_PAD:  resume <= ST_PAD;
        ST_LEN:  resume <= ST_OUT;
        default: resume <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_first <= 1'b0;
    end else if (in_fire && (in_data.req_type == REQ_FINISH)) begin
      pad_first <= 1'b1;
    end else if (state == ST_PAD) begin
      pad_first <= 1'b0;
    end
  end

  // Capture the message length on finish; shift out one byte per length slot
  always_ff @(posedge clk) begin
    if (in_fire && (in_data.req_type == REQ_FINISH)) begin
      length <= bit_count;
    end else if (state == ST_LEN) begin
      length <= {length[55:0], ZERO_BYTE};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count <= '0;
    end else if (out_valid && out_ready) begin
      bit_count <= '0;
    end else if (ctl.absorb) begin
      bit_count <= bit_count + 64'd8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= CHAIN_INIT;
    end else if (out_valid && out_ready) begin
      chain <= CHAIN_INIT;
    end else if (state == ST_ADD) begin
      chain.a <= chain.a + work.a;
      chain.b <= chain.b + work.b;
      chain.c <= chain.c + work.c;
      chain.d <= chain.d + work.d;
      chain.e <= chain.e + work.e;
    end
  end

  assign out_data.digest_word0 = chain.a;
  assign out_data.digest_word1 = chain.b;
  assign out_data.digest_word2 = chain.c;
  assign out_data.digest_word3 = chain.d;
  assign out_data.digest_word4 = chain.e;

`ifndef NO_ASSERTIONS
  // Never take a word while a digest is on offer
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input taken while digest pending");

  // A compression only runs on a completed block
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> (bit_count[8:0] == 9'd0))
    else $error("compression on a partial block");

  // Length bytes occupy the last eight slots of a block
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEN) |-> (bit_count[8:6] == 3'b111))
    else $error("length bytes misplaced");

  // The padded message ends on a block boundary
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bit_count[8:0] == 9'd0))
    else $error("digest without block alignment");
`endif

endmodule
